// ----- design/asr_pkg.sv -----
// ----------------------------------------------------------------------------
// Advection stencil residual package
// Shared constants, microcode types and the control program of the sequencer.
// ----------------------------------------------------------------------------
package asr_pkg;

	localparam int DEF_DATA_WIDTH = 32;
	localparam int DEF_FRAC_BITS  = 16;

	// Fromm face fluxes carry an extra division by eight.
	localparam int FROMM_SHIFT = 3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SCHEME = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DZ = 2'd2;

	localparam logic SCHEME_UPWIND = 1'b0;
	localparam logic SCHEME_FROMM  = 1'b1;
	localparam logic AXIS_H        = 1'b0;
	localparam logic AXIS_V        = 1'b1;

	localparam int PROG_LEN = 22;
	localparam int PC_W     = 5;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t PC_SCALE = pc_t'(6);
	localparam pc_t PC_FROMM = pc_t'(12);

	typedef enum logic [2:0] {
		OP_PREP,
		OP_LOAD,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_ACC,
		OP_NORM,
		OP_FINISH
	} uop_t;

	typedef enum logic [1:0] {
		SEL_UPWIND,
		SEL_FACE_P,
		SEL_FACE_M,
		SEL_SCALE
	} sel_t;

	typedef enum logic {
		DST_T0,
		DST_T1
	} dst_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_FROMM,
		JMP_ALWAYS
	} jump_t;

	typedef struct packed {
		uop_t  op;
		sel_t  sel;
		logic  wide_shift;
		dst_t  dst;
		jump_t jump;
		pc_t   target;
	} ctrl_t;

	function automatic ctrl_t cw(uop_t op, sel_t sel, logic wide_shift, dst_t dst,
			jump_t jump, pc_t target);
		ctrl_t c;
		c.op         = op;
		c.sel        = sel;
		c.wide_shift = wide_shift;
		c.dst        = dst;
		c.jump       = jump;
		c.target     = target;
		return c;
	endfunction

	// Upwind runs the first product and the scaling product; Fromm runs two
	// face products and then joins the scaling product.
	function automatic ctrl_t ucode(pc_t pc);
		ctrl_t c;
		unique case (pc)
			pc_t'(0):  c = cw(OP_PREP,   SEL_UPWIND, 1'b0, DST_T0, JMP_FROMM,  PC_FROMM);
			pc_t'(1):  c = cw(OP_LOAD,   SEL_UPWIND, 1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(2):  c = cw(OP_MUL_LO, SEL_UPWIND, 1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(3):  c = cw(OP_MUL_HI, SEL_UPWIND, 1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(4):  c = cw(OP_ACC,    SEL_UPWIND, 1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(5):  c = cw(OP_NORM,   SEL_UPWIND, 1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(6):  c = cw(OP_LOAD,   SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(7):  c = cw(OP_MUL_LO, SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(8):  c = cw(OP_MUL_HI, SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(9):  c = cw(OP_ACC,    SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(10): c = cw(OP_NORM,   SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(11): c = cw(OP_FINISH, SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
			pc_t'(12): c = cw(OP_LOAD,   SEL_FACE_P, 1'b1, DST_T0, JMP_NONE,   '0);
			pc_t'(13): c = cw(OP_MUL_LO, SEL_FACE_P, 1'b1, DST_T0, JMP_NONE,   '0);
			pc_t'(14): c = cw(OP_MUL_HI, SEL_FACE_P, 1'b1, DST_T0, JMP_NONE,   '0);
			pc_t'(15): c = cw(OP_ACC,    SEL_FACE_P, 1'b1, DST_T0, JMP_NONE,   '0);
			pc_t'(16): c = cw(OP_NORM,   SEL_FACE_P, 1'b1, DST_T0, JMP_NONE,   '0);
			pc_t'(17): c = cw(OP_LOAD,   SEL_FACE_M, 1'b1, DST_T1, JMP_NONE,   '0);
			pc_t'(18): c = cw(OP_MUL_LO, SEL_FACE_M, 1'b1, DST_T1, JMP_NONE,   '0);
			pc_t'(19): c = cw(OP_MUL_HI, SEL_FACE_M, 1'b1, DST_T1, JMP_NONE,   '0);
			pc_t'(20): c = cw(OP_ACC,    SEL_FACE_M, 1'b1, DST_T1, JMP_NONE,   '0);
			pc_t'(21): c = cw(OP_NORM,   SEL_FACE_M, 1'b1, DST_T1, JMP_ALWAYS, PC_SCALE);
			default:   c = cw(OP_FINISH, SEL_SCALE,  1'b0, DST_T0, JMP_NONE,   '0);
		endcase
		return c;
	endfunction

endpackage

// ----- design/asr_ifs.sv -----
// ----------------------------------------------------------------------------
// Advection stencil residual channels
// Valid/ready channels for axis line words, residual words and register writes.
// ----------------------------------------------------------------------------
interface asr_in_if import asr_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic                         axis;
	logic signed [DATA_WIDTH-1:0] v_minus;
	logic signed [DATA_WIDTH-1:0] v_plus;
	logic signed [DATA_WIDTH-1:0] x_far_minus;
	logic signed [DATA_WIDTH-1:0] x_minus;
	logic signed [DATA_WIDTH-1:0] x_center;
	logic signed [DATA_WIDTH-1:0] x_plus;
	logic signed [DATA_WIDTH-1:0] x_far_plus;

	modport source (
		output valid, axis, v_minus, v_plus, x_far_minus, x_minus, x_center, x_plus,
			x_far_plus,
		input  ready
	);
	modport sink (
		input  valid, axis, v_minus, v_plus, x_far_minus, x_minus, x_center, x_plus,
			x_far_plus,
		output ready
	);
endinterface

interface asr_out_if import asr_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] residual;

	modport source (output valid, residual, input ready);
	modport sink (input valid, residual, output ready);
endinterface

interface asr_cfg_if import asr_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
);
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [DATA_WIDTH-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/advection_stencil_residual.sv -----
// ----------------------------------------------------------------------------
// Advection stencil residual
// Upwind or Fromm advection residual of one grid point, one axis line per word,
// run by a microcoded sequencer around one shared multiplier.
// ----------------------------------------------------------------------------
// A vertical word gives a residual word once its upwind or Fromm program ends;
// a horizontal word gives none. A new word is taken only once the last is done.
// The sequencer runs one microcode step per cycle unless the result stalls it at
// the finish step; each multiply takes two partial products.
// Reset: asynchronous; control and configuration registers reset, the stored
// horizontal term clears to zero and the block is ready at once.
module advection_stencil_residual import asr_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	asr_in_if.sink          item,
	asr_out_if.source       result,
	asr_cfg_if.sink         cfg
);

	localparam int DW = DATA_WIDTH;
	localparam int SW = DW + 5;
	localparam int MW = DW + 4;
	localparam int H  = (MW + 1) / 2;
	localparam int HW = MW - H;
	localparam int PW = 2 * MW + 1;

	localparam logic [PW-1:0] LIM_POS = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic [PW-1:0] LIM_NEG = LIM_POS + PW'(1);
	localparam logic [PW-1:0] RND_N   = {{(PW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};
	localparam logic [PW-1:0] RND_W   =
		{{(PW-FRAC_BITS-FROMM_SHIFT){1'b0}}, {(FRAC_BITS+FROMM_SHIFT){1'b1}}};
	localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic signed [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	// Control and configuration state.
	logic          busy_q;
	pc_t           pc_q;
	logic          res_valid_q;
	logic          scheme_sel_q;
	logic [DW-1:0] inv_dx_q;
	logic [DW-1:0] inv_dz_q;
	logic signed [DW-1:0] horiz_q;

	// Item registers.
	logic                 axis_q;
	logic                 scheme_q;
	logic signed [DW-1:0] vm_q, vp_q, xfm_q, xm_q, xc_q, xp_q, xfp_q;

	// Datapath registers.
	logic signed [DW-1:0] vel_q;
	logic signed [DW:0]   d_q;
	logic signed [SW-1:0] ap_q, bp_q, am_q, bm_q;
	logic                 neg_q;
	logic [MW-1:0]        mag_a_q, mag_b_q;
	logic [MW+H-1:0]      pp_q;
	logic [PW-1:0]        acc_q;
	logic signed [DW-1:0] t0_q, t1_q;
	logic signed [DW-1:0] res_q;

	ctrl_t ctrl;
	logic  accept;
	logic  cfg_wr;
	logic  finish, finish_done, emit, jump_taken;

	logic signed [DW:0]   sum_v;
	logic signed [DW-1:0] vel_d;
	logic signed [DW:0]   d_d;
	logic signed [SW-1:0] tp, tm, up, um, ap_d, bp_d, am_d, bm_d;
	logic signed [SW-1:0] op_a, op_b, abs_a, abs_b;
	logic [H-1:0]         mul_b;
	logic [MW+H-1:0]      mul_out;
	logic [PW-1:0]        rnd;
	logic [PW-1:0]        q;
	logic                 over;
	logic signed [DW-1:0] norm_val;
	logic signed [DW:0]   fsum;
	logic signed [DW-1:0] fsat;

	assign ctrl        = ucode(pc_q);
	assign item.ready  = !busy_q;
	assign accept      = item.valid && item.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_wr      = cfg.valid && cfg.ready;
	assign result.valid    = res_valid_q;
	assign result.residual = res_q;

	assign finish      = busy_q && (ctrl.op == OP_FINISH);
	assign emit        = finish && (axis_q == AXIS_V) && (!res_valid_q || result.ready);
	assign finish_done = finish && ((axis_q == AXIS_H) || emit);

	always_comb begin
		unique case (ctrl.jump)
			JMP_FROMM:  jump_taken = (scheme_q == SCHEME_FROMM);
			JMP_ALWAYS: jump_taken = 1'b1;
			default:    jump_taken = 1'b0;
		endcase
	end

	// Stencil preparation: upwind velocity and difference, Fromm a and b terms.
	always_comb begin
		sum_v = {vm_q[DW-1], vm_q} + {vp_q[DW-1], vp_q};
		vel_d = sum_v[DW:1];
		d_d   = sum_v[DW] ? ({xp_q[DW-1], xp_q} - {xc_q[DW-1], xc_q})
			: ({xc_q[DW-1], xc_q} - {xm_q[DW-1], xm_q});
		tp    = SW'(xp_q) + SW'(xc_q);
		up    = SW'(xp_q) - SW'(xc_q);
		tm    = SW'(xc_q) + SW'(xm_q);
		um    = SW'(xc_q) - SW'(xm_q);
		ap_d  = tp + (tp <<< 2) - SW'(xfp_q) - SW'(xm_q);
		bp_d  = up + (up <<< 1) - SW'(xfp_q) + SW'(xm_q);
		am_d  = tm + (tm <<< 2) - SW'(xp_q) - SW'(xfm_q);
		bm_d  = um + (um <<< 1) - SW'(xp_q) + SW'(xfm_q);
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (ctrl.sel)
			SEL_UPWIND: begin
				op_a = SW'(vel_q);
				op_b = SW'(d_q);
			end
			SEL_FACE_P: begin
				op_a = SW'(vp_q);
				op_b = vp_q[DW-1] ? (ap_q + bp_q) : (ap_q - bp_q);
			end
			SEL_FACE_M: begin
				op_a = SW'(vm_q);
				op_b = vm_q[DW-1] ? (am_q + bm_q) : (am_q - bm_q);
			end
			SEL_SCALE: begin
				op_a = SW'(t0_q) - SW'(t1_q);
				op_b = (axis_q == AXIS_V) ? $signed(SW'(inv_dz_q)) : $signed(SW'(inv_dx_q));
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		abs_a = op_a[SW-1] ? -op_a : op_a;
		abs_b = op_b[SW-1] ? -op_b : op_b;
	end

	always_comb begin
		mul_b   = (ctrl.op == OP_MUL_HI) ? H'(mag_b_q[MW-1:H]) : mag_b_q[H-1:0];
		mul_out = mag_a_q * mul_b;
		if (neg_q) begin
			rnd = ctrl.wide_shift ? RND_W : RND_N;
		end else begin
			rnd = '0;
		end
	end

	// Floor shift, then saturation to the data range.
	always_comb begin
		q        = ctrl.wide_shift ? (acc_q >> (FRAC_BITS + FROMM_SHIFT)) : (acc_q >> FRAC_BITS);
		over     = q > (neg_q ? LIM_NEG : LIM_POS);
		if (over) begin
			norm_val = neg_q ? MINV : MAXV;
		end else begin
			norm_val = neg_q ? -$signed(q[DW-1:0]) : $signed(q[DW-1:0]);
		end
		fsum = {horiz_q[DW-1], horiz_q} + {t0_q[DW-1], t0_q};
		if (fsum[DW] != fsum[DW-1]) begin
			fsat = fsum[DW] ? MINV : MAXV;
		end else begin
			fsat = fsum[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pc_q         <= '0;
			res_valid_q  <= 1'b0;
			scheme_sel_q <= SCHEME_UPWIND;
			inv_dx_q     <= DW'(1) << FRAC_BITS;
			inv_dz_q     <= DW'(1) << FRAC_BITS;
			horiz_q      <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg.index)
					REG_SCHEME: scheme_sel_q <= cfg.data[0];
					REG_INV_DX: inv_dx_q     <= cfg.data;
					REG_INV_DZ: inv_dz_q     <= cfg.data;
					default:    ;
				endcase
			end
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end else if (finish_done) begin
				busy_q <= 1'b0;
			end else if (busy_q && !finish) begin
				pc_q <= jump_taken ? ctrl.target : pc_q + pc_t'(1);
			end
			if (finish_done) begin
				horiz_q <= (axis_q == AXIS_H) ? t0_q : '0;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			axis_q   <= item.axis;
			scheme_q <= scheme_sel_q;
			vm_q     <= item.v_minus;
			vp_q     <= item.v_plus;
			xfm_q    <= item.x_far_minus;
			xm_q     <= item.x_minus;
			xc_q     <= item.x_center;
			xp_q     <= item.x_plus;
			xfp_q    <= item.x_far_plus;
		end
		if (busy_q) begin
			unique case (ctrl.op)
				OP_PREP: begin
					vel_q <= vel_d;
					d_q   <= d_d;
					ap_q  <= ap_d;
					bp_q  <= bp_d;
					am_q  <= am_d;
					bm_q  <= bm_d;
					t1_q  <= '0;
				end
				OP_LOAD: begin
					neg_q   <= op_a[SW-1] ^ op_b[SW-1];
					mag_a_q <= abs_a[MW-1:0];
					mag_b_q <= abs_b[MW-1:0];
				end
				OP_MUL_LO: begin
					pp_q <= mul_out;
				end
				OP_MUL_HI: begin
					pp_q  <= mul_out;
					acc_q <= PW'(pp_q);
				end
				OP_ACC: begin
					acc_q <= acc_q + (PW'(pp_q) << H) + rnd;
				end
				OP_NORM: begin
					if (ctrl.dst == DST_T1) begin
						t1_q <= norm_val;
					end else begin
						t0_q <= norm_val;
					end
				end
				OP_FINISH: begin
					if (emit) begin
						res_q <= fsat;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_from_vertical: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> (axis_q == AXIS_V))
		else $error("residual word raised after a horizontal line");

	a_term_cleared_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> (horiz_q == '0))
		else $error("horizontal term not cleared when residual word was raised");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (pc_q < pc_t'(PROG_LEN)))
		else $error("step counter left the control program");

	a_hi_part_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && ctrl.op == OP_MUL_HI) |=> (HW <= H))
		else $error("multiplier high part wider than its port");
`endif

endmodule
